@@ rtl/core/tdc_pkg.sv @@
package tdc_pkg;

	localparam logic [7:0] TPS_RESET   = 8'd125;
	localparam logic [5:0] SEC_RESET   = 6'd0;
	localparam logic [5:0] MIN_RESET   = 6'd7;
	localparam logic [4:0] HOUR_RESET  = 5'd11;
	localparam logic [5:0] SEC_MAX     = 6'd59;
	localparam logic [5:0] MIN_MAX     = 6'd59;
	localparam logic [4:0] HOUR_MAX    = 5'd23;

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_FAULT  = 8'h00;

	localparam int         NUM_CHARS   = 8;
	localparam logic [3:0] IDX_LAST_CH = 4'd7;
	localparam logic [3:0] IDX_FAULT   = 4'd8;

	// new time handed from the counter to the display buffer
	typedef struct packed {
		logic       load;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       late;
	} frame_t;

	// tens digit of a value 0..63 by compare chain
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		if (v >= 6'd60)      t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else                 t = 3'd0;
		return t;
	endfunction

	function automatic logic [3:0] ones_of(input logic [5:0] v);
		logic [2:0] t;
		logic [5:0] r;
		t = tens_of(v);
		// v - 10*t
		r = v - {t, 3'b000} - {2'b00, t, 1'b0};
		return r[3:0];
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return CHAR_ZERO + {4'h0, d};
	endfunction

endpackage

@@ rtl/core/time_of_day_clock_display_core.sv @@
// channel  | dir | signals                         | word
// s        | in  | s_tvalid s_tready s_tdata       | one timer tick, late flag
// m        | out | m_tvalid m_tready m_tdata/tlast | one display character
// cfg      | in  | cfg_valid cfg_ready cfg_data    | ticks_per_second
//
// A tick that does not finish a second is taken every cycle.
// A second rollover loads eight characters (nine with a fault word) into the
// display buffer; they leave one per cycle while m is ready, so a rolling tick
// holds the buffer until its last word leaves by the buffer's single output port.
// The next rolling tick is taken in the cycle the last word leaves.
// Reset is asynchronous; time starts at 11:07:00 with 125 ticks per second.
// A stall on m holds the current word; ticks that do not roll still flow.
module time_of_day_clock_display_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] late, [7:1] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] character
	output logic       m_tlast,
	output logic       m_tuser,   // [0] fault
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	tdc_pkg::frame_t frame;
	logic            roll_next;
	logic            frame_free;
	logic            tick;

	assign cfg_ready = 1'b1;
	// only a tick that rolls the second needs the buffer
	assign s_tready  = !roll_next || frame_free;
	assign tick      = s_tvalid && s_tready;

	tdc_time u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.late      (s_tdata[0]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.roll_next (roll_next),
		.frame     (frame)
	);

	tdc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.frame_free (frame_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (m_tdata),
		.out_last   (m_tlast),
		.out_fault  (m_tuser)
	);

endmodule

@@ rtl/core/tdc_time.sv @@
module tdc_time (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                late,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data,
	output logic                roll_next,
	output tdc_pkg::frame_t     frame
);

	logic [7:0] tps_q;
	logic [7:0] count_q;
	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic       halted_q;

	logic [7:0] count_inc;
	logic [5:0] sec_nx;
	logic [5:0] min_nx;
	logic [4:0] hour_nx;
	logic       roll;

	assign count_inc = count_q + 8'd1;
	assign roll_next = !halted_q && (count_inc == tps_q);
	assign roll      = tick && roll_next;

	always_comb begin
		sec_nx  = sec_q;
		min_nx  = min_q;
		hour_nx = hour_q;
		if (sec_q >= tdc_pkg::SEC_MAX) begin
			sec_nx = '0;
			if (min_q >= tdc_pkg::MIN_MAX) begin
				min_nx = '0;
				if (hour_q >= tdc_pkg::HOUR_MAX) begin
					hour_nx = '0;
				end else begin
					hour_nx = hour_q + 5'd1;
				end
			end else begin
				min_nx = min_q + 6'd1;
			end
		end else begin
			sec_nx = sec_q + 6'd1;
		end
	end

	assign frame.load    = roll;
	assign frame.hours   = hour_nx;
	assign frame.minutes = min_nx;
	assign frame.seconds = sec_nx;
	assign frame.late    = late;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q    <= tdc_pkg::TPS_RESET;
			count_q  <= '0;
			sec_q    <= tdc_pkg::SEC_RESET;
			min_q    <= tdc_pkg::MIN_RESET;
			hour_q   <= tdc_pkg::HOUR_RESET;
			halted_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			// halted: drop the tick without touching state
			if (tick && !halted_q) begin
				if (roll) begin
					count_q <= '0;
					sec_q   <= sec_nx;
					min_q   <= min_nx;
					hour_q  <= hour_nx;
					if (late) begin
						halted_q <= 1'b1;
					end
				end else begin
					count_q <= count_inc;
				end
			end
		end
	end

endmodule

@@ rtl/core/tdc_frame.sv @@
module tdc_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  tdc_pkg::frame_t frame,
	output logic            frame_free,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_char,
	output logic            out_last,
	output logic            out_fault
);

	logic [7:0] chars_s1 [tdc_pkg::NUM_CHARS];
	logic       late_s1;
	logic       busy_q;
	logic [3:0] idx_q;

	logic [2:0] hour_tens;
	logic       take;

	assign hour_tens = tdc_pkg::tens_of({1'b0, frame.hours});

	assign out_valid = busy_q;
	assign out_fault = (idx_q == tdc_pkg::IDX_FAULT);
	assign out_char  = out_fault ? tdc_pkg::CHAR_FAULT : chars_s1[idx_q[2:0]];
	assign out_last  = late_s1 ? out_fault : (idx_q == tdc_pkg::IDX_LAST_CH);

	assign take       = busy_q && out_ready;
	assign frame_free = !busy_q || (take && out_last);

	always_ff @(posedge clk) begin
		if (frame.load) begin
			chars_s1[0] <= (hour_tens == 3'd0) ? tdc_pkg::CHAR_SPACE
			                                   : tdc_pkg::digit_char({1'b0, hour_tens});
			chars_s1[1] <= tdc_pkg::digit_char(tdc_pkg::ones_of({1'b0, frame.hours}));
			chars_s1[2] <= tdc_pkg::CHAR_COLON;
			chars_s1[3] <= tdc_pkg::digit_char({1'b0, tdc_pkg::tens_of(frame.minutes)});
			chars_s1[4] <= tdc_pkg::digit_char(tdc_pkg::ones_of(frame.minutes));
			chars_s1[5] <= tdc_pkg::CHAR_COLON;
			chars_s1[6] <= tdc_pkg::digit_char({1'b0, tdc_pkg::tens_of(frame.seconds)});
			chars_s1[7] <= tdc_pkg::digit_char(tdc_pkg::ones_of(frame.seconds));
			late_s1     <= frame.late;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (frame.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (out_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

endmodule

@@ rtl/core/tdc_checker.sv @@
module tdc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// a fault word always closes the run and carries no character
	a_fault_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == tdc_pkg::CHAR_FAULT))
		else $error("fault word without tlast or with a character");

	// after the fault the block is halted for good
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser |=> !m_tvalid)
		else $error("word after fault");

	// a display word is never a NUL
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata != 8'h00)
		else $error("display word is zero");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("stalled word changed");

endmodule

bind time_of_day_clock_display_core tdc_checker u_tdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
